FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lpbd_pkg.sv
// ----------------------------------------------------------------------------
// lpbd_pkg
// Shared types and constants of the LRU page buffer directory.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbd_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } lpbd_mode_e;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_FETCH  = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_DELETE = 2'd3
  } lpbd_req_e;

  typedef enum logic {
    REG_CAPACITY      = 1'b0,
    REG_WRITE_THROUGH = 1'b1
  } lpbd_reg_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] page;
  } lpbd_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [1:0]  backing_request;
    logic        evicted;
    logic [31:0] evicted_page;
    logic        evict_writeback;
    logic [31:0] hit_count;
  } lpbd_out_t;

  typedef struct packed {
    logic [OCC_W-1:0] eff_cap;
    logic             write_through;
  } lpbd_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             evict;
    logic [IDX_W-1:0] lru_idx;
    logic [IDX_W-1:0] free_idx;
  } lpbd_look_t;

  typedef logic [ENTRIES-1:0][31:0]       tag_vec_t;
  typedef logic [ENTRIES-1:0][RANK_W-1:0] rank_vec_t;

  function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] idx);
    return 4'(idx);
  endfunction

endpackage

`default_nettype wire

FILE: src/lpbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpbd_cfg_regs
// APB configuration registers: capacity and write-through mode.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lpbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [lpbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output lpbd_pkg::lpbd_cfg_t               cfg_o
);

  logic [4:0]          capacity_q;
  logic                write_through_q;
  logic                wr_en;
  lpbd_pkg::lpbd_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = lpbd_pkg::lpbd_reg_e'(paddr[lpbd_pkg::REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q      <= lpbd_pkg::CAPACITY_RESET;
      write_through_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        lpbd_pkg::REG_CAPACITY:      capacity_q      <= pwdata[4:0];
        lpbd_pkg::REG_WRITE_THROUGH: write_through_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lpbd_pkg::REG_CAPACITY:      prdata = {{(lpbd_pkg::DATA_W-5){1'b0}}, capacity_q};
      lpbd_pkg::REG_WRITE_THROUGH: prdata = {{(lpbd_pkg::DATA_W-1){1'b0}}, write_through_q};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.write_through = write_through_q;
    priority if (capacity_q == 5'd0) begin
      cfg_o.eff_cap = lpbd_pkg::OCC_W'(1);
    end else if (32'(capacity_q) > 32'(lpbd_pkg::ENTRIES)) begin
      cfg_o.eff_cap = lpbd_pkg::OCC_W'(lpbd_pkg::ENTRIES);
    end else begin
      cfg_o.eff_cap = lpbd_pkg::OCC_W'(capacity_q);
    end
  end

endmodule

`default_nettype wire

FILE: src/lpbd_lookup.sv
// ----------------------------------------------------------------------------
// lpbd_lookup
// Parallel tag match, LRU entry pick and free slot pick.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_lookup (
  input  wire lpbd_pkg::tag_vec_t            tags_i,
  input  wire logic [lpbd_pkg::ENTRIES-1:0]  valid_i,
  input  wire lpbd_pkg::rank_vec_t           rank_i,
  input  wire logic [31:0]                   page_i,
  input  wire logic [lpbd_pkg::OCC_W-1:0]    occ_i,
  input  wire lpbd_pkg::lpbd_cfg_t           cfg_i,
  output lpbd_pkg::lpbd_look_t               look_o
);

  logic lru_found;

  always_comb begin
    look_o    = '0;
    lru_found = 1'b0;
    for (int i = lpbd_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (tags_i[i] == page_i)) begin
        look_o.hit     = 1'b1;
        look_o.hit_idx = lpbd_pkg::IDX_W'(i);
      end
      if (valid_i[i] && (rank_i[i] == '0)) begin
        lru_found      = 1'b1;
        look_o.lru_idx = lpbd_pkg::IDX_W'(i);
      end
    end
    look_o.evict = lru_found && (occ_i >= cfg_i.eff_cap);
    for (int i = lpbd_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i] || (look_o.evict && (look_o.lru_idx == lpbd_pkg::IDX_W'(i)))) begin
        look_o.free_idx = lpbd_pkg::IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/lpbd_state.sv
// ----------------------------------------------------------------------------
// lpbd_state
// Directory state and its registered update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_state (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire lpbd_pkg::lpbd_in_t    item_i,
  input  wire lpbd_pkg::lpbd_cfg_t   cfg_i,
  output lpbd_pkg::lpbd_out_t        res_o
);

  lpbd_pkg::tag_vec_t                tags_q, tags_d;
  logic [lpbd_pkg::ENTRIES-1:0]      valid_q, valid_d;
  logic [lpbd_pkg::ENTRIES-1:0]      dirty_q, dirty_d;
  lpbd_pkg::rank_vec_t               rank_q, rank_d;
  logic [lpbd_pkg::OCC_W-1:0]        occ_q, occ_d;
  logic [31:0]                       hits_q, hits_d;

  lpbd_pkg::lpbd_look_t              look;
  lpbd_pkg::lpbd_mode_e              mode;
  logic                              is_del;
  logic                              alloc;
  logic                              evict;
  logic                              count_hit;
  logic [lpbd_pkg::RANK_W-1:0]       hit_rank;

  lpbd_lookup u_lookup (
    .tags_i (tags_q),
    .valid_i(valid_q),
    .rank_i (rank_q),
    .page_i (item_i.page),
    .occ_i  (occ_q),
    .cfg_i  (cfg_i),
    .look_o (look)
  );

  assign mode     = lpbd_pkg::lpbd_mode_e'(item_i.mode);
  assign is_del   = (mode == lpbd_pkg::MODE_DELETE);
  assign alloc    = !look.hit && !is_del;
  assign evict    = alloc && look.evict;
  assign hit_rank = rank_q[look.hit_idx];
  assign count_hit = look.hit && ((mode == lpbd_pkg::MODE_READ) ||
                                  ((mode == lpbd_pkg::MODE_STORE) && !cfg_i.write_through));

  always_comb begin
    tags_d  = tags_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    hits_d  = hits_q;

    for (int i = 0; i < lpbd_pkg::ENTRIES; i++) begin
      if (valid_q[i]) begin
        if (look.hit && (rank_q[i] > hit_rank)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end else if (evict && (rank_q[i] != '0)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end
      end
    end

    if (look.hit) begin
      if (is_del) begin
        valid_d[look.hit_idx] = 1'b0;
        dirty_d[look.hit_idx] = 1'b0;
        rank_d[look.hit_idx]  = '0;
        occ_d                 = occ_q - 1'b1;
      end else begin
        rank_d[look.hit_idx] = lpbd_pkg::RANK_W'(occ_q - 1'b1);
        if (mode == lpbd_pkg::MODE_STORE) begin
          dirty_d[look.hit_idx] = !cfg_i.write_through;
        end else if (mode == lpbd_pkg::MODE_INSERT) begin
          dirty_d[look.hit_idx] = 1'b0;
        end
      end
    end else if (alloc) begin
      if (evict) begin
        valid_d[look.lru_idx] = 1'b0;
        dirty_d[look.lru_idx] = 1'b0;
      end
      tags_d[look.free_idx]  = item_i.page;
      valid_d[look.free_idx] = 1'b1;
      dirty_d[look.free_idx] = (mode == lpbd_pkg::MODE_STORE) && !cfg_i.write_through;
      if (evict) begin
        rank_d[look.free_idx] = lpbd_pkg::RANK_W'(occ_q - 1'b1);
      end else begin
        rank_d[look.free_idx] = lpbd_pkg::RANK_W'(occ_q);
        occ_d                 = occ_q + 1'b1;
      end
    end

    if (count_hit && (hits_q != '1)) begin
      hits_d = hits_q + 1'b1;
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.hit             = look.hit;
    res_o.evicted         = evict;
    res_o.evicted_page    = evict ? tags_q[look.lru_idx] : 32'd0;
    res_o.evict_writeback = evict && dirty_q[look.lru_idx];
    res_o.hit_count       = hits_d;
    if (is_del) begin
      res_o.slot = 4'd0;
    end else if (look.hit) begin
      res_o.slot = lpbd_pkg::to_slot(look.hit_idx);
    end else begin
      res_o.slot = lpbd_pkg::to_slot(look.free_idx);
    end
    unique case (mode)
      lpbd_pkg::MODE_READ:   res_o.backing_request = look.hit ? lpbd_pkg::REQ_NONE
                                                              : lpbd_pkg::REQ_FETCH;
      lpbd_pkg::MODE_STORE:  res_o.backing_request = cfg_i.write_through ? lpbd_pkg::REQ_WRITE
                                                                         : lpbd_pkg::REQ_NONE;
      lpbd_pkg::MODE_INSERT: res_o.backing_request = lpbd_pkg::REQ_WRITE;
      lpbd_pkg::MODE_DELETE: res_o.backing_request = lpbd_pkg::REQ_DELETE;
      default:               res_o.backing_request = lpbd_pkg::REQ_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      tags_q <= tags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      rank_q  <= '0;
      occ_q   <= '0;
      hits_q  <= '0;
    end else if (fire_i) begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      rank_q  <= rank_d;
      occ_q   <= occ_d;
      hits_q  <= hits_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/lru_page_buffer_directory.sv
// Flow: a request is captured in the input register and its result then in the
// result register, raising out_valid_o; a stalled held result delays this.
// Throughput: one request per cycle while the output is not stalled; tag match
// and rank update are combinational between the input and result registers.
// Reset: asynchronous, active low; empties the directory, clears the hit count,
// sets capacity to 16 and selects write-back.
// ----------------------------------------------------------------------------
// lru_page_buffer_directory
// Directory of a fully associative LRU page buffer with APB configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_buffer_directory (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire lpbd_pkg::lpbd_in_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output lpbd_pkg::lpbd_out_t               out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lpbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [lpbd_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  lpbd_pkg::lpbd_cfg_t cfg;
  lpbd_pkg::lpbd_in_t  in_q;
  logic                in_vld_q;
  lpbd_pkg::lpbd_out_t out_q;
  logic                out_vld_q;
  lpbd_pkg::lpbd_out_t res;
  logic                out_free;
  logic                fire;

  lpbd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  lpbd_state u_state (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign out_free    = !out_vld_q || !out_stall_i;
  assign fire        = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/lpbd_checker.sv
// ----------------------------------------------------------------------------
// lpbd_checker
// Port-level checks of the LRU page buffer directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpbd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_i,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire lpbd_pkg::lpbd_out_t out_data_i
);

  logic res_held;
  logic res_plain;
  logic evict_clear;
  logic res_delete;
  logic delete_clear;
  logic res_fetch;

  assign res_held     = out_valid_i && out_stall_i;
  assign res_plain    = out_valid_i && !out_data_i.evicted;
  assign evict_clear  = (out_data_i.evicted_page == 32'd0) && !out_data_i.evict_writeback;
  assign res_delete   = out_valid_i && (out_data_i.backing_request == lpbd_pkg::REQ_DELETE);
  assign delete_clear = (out_data_i.slot == 4'd0) && !out_data_i.evicted;
  assign res_fetch    = out_valid_i && (out_data_i.backing_request == lpbd_pkg::REQ_FETCH);

  `ASSERT_NEXT(a_out_hold, res_held, out_valid_i && $stable(out_data_i), "stalled result changed")
  `ASSERT_IMPLY(a_no_stall_when_empty, !out_valid_i, !in_stall_i, "stall with empty output")
  `ASSERT_IMPLY(a_evict_fields, res_plain, evict_clear, "eviction fields set without eviction")
  `ASSERT_IMPLY(a_delete_result, res_delete, delete_clear, "delete result with slot or eviction")
  `ASSERT_IMPLY(a_fetch_is_miss, res_fetch, !out_data_i.hit, "fetch requested on a hit")

endmodule

bind lru_page_buffer_directory lpbd_checker u_lpbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU page buffer directory. A behavioural copy of
// the directory predicts every result; directed access, capacity and
// write-through tests are followed by randomised traffic and a backpressure
// test under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 6;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 75;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  lpbd_pkg::lpbd_in_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  lpbd_pkg::lpbd_out_t           out_data_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [lpbd_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [lpbd_pkg::DATA_W-1:0]   pwdata      = '0;
  logic [lpbd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // directory copy
  logic [31:0]  tag_q   [lpbd_pkg::ENTRIES];
  bit           valid_q [lpbd_pkg::ENTRIES] = '{default: 1'b0};
  bit           dirty_q [lpbd_pkg::ENTRIES] = '{default: 1'b0};
  int unsigned  rank_q  [lpbd_pkg::ENTRIES] = '{default: 0};
  int unsigned  occ_q             = 0;
  logic [31:0]  hits_q            = '0;
  logic [4:0]   cap_reg           = lpbd_pkg::CAPACITY_RESET;
  bit           wt_reg            = 1'b0;

  lpbd_pkg::lpbd_out_t pending_replies [$];
  lpbd_pkg::lpbd_out_t want;
  int           fail_count  = 0;
  int           idle_pct    = 0;
  int           stall_pct   = 0;
  int           hold_cycles = 0;
  logic [31:0]  page_pool [POOL_SIZE];

  int           idle_plan  [4]      = '{0, 59, 0, 8};
  int           stall_plan [4]      = '{0, 0, 59, 8};
  logic [4:0]   cap_plan   [PHASES] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd2};
  bit           wt_plan    [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  lru_page_buffer_directory uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void promote_entry(int s);
    int unsigned r = rank_q[s];
    for (int i = 0; i < lpbd_pkg::ENTRIES; i++)
      if (valid_q[i] && rank_q[i] > r) rank_q[i]--;
    rank_q[s] = (occ_q != 0) ? occ_q - 1 : 0;
  endfunction

  function automatic void drop_entry(int s);
    int unsigned r = rank_q[s];
    valid_q[s] = 1'b0;
    dirty_q[s] = 1'b0;
    rank_q[s]  = 0;
    for (int i = 0; i < lpbd_pkg::ENTRIES; i++)
      if (valid_q[i] && rank_q[i] > r) rank_q[i]--;
    if (occ_q != 0) occ_q--;
  endfunction

  function automatic int claim_entry(logic [31:0] page, bit dirty,
                                     inout lpbd_pkg::lpbd_out_t res);
    int          lru = -1;
    int          s   = 0;
    int unsigned cap;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > lpbd_pkg::ENTRIES) ? lpbd_pkg::ENTRIES : cap_reg);
    if (occ_q >= cap && occ_q > 0) begin
      for (int i = 0; i < lpbd_pkg::ENTRIES; i++)
        if (valid_q[i] && (lru < 0 || rank_q[i] < rank_q[lru])) lru = i;
      if (lru >= 0) begin
        res.evicted         = 1'b1;
        res.evicted_page    = tag_q[lru];
        res.evict_writeback = dirty_q[lru];
        drop_entry(lru);
      end
    end
    for (int i = lpbd_pkg::ENTRIES - 1; i >= 0; i--)
      if (!valid_q[i]) s = i;
    tag_q[s]   = page;
    valid_q[s] = 1'b1;
    dirty_q[s] = dirty;
    rank_q[s]  = occ_q;
    occ_q++;
    return s;
  endfunction

  function automatic lpbd_pkg::lpbd_out_t predict_directory(lpbd_pkg::lpbd_in_t req);
    lpbd_pkg::lpbd_out_t res  = '0;
    int                  s    = -1;
    int                  slot = 0;
    for (int i = 0; i < lpbd_pkg::ENTRIES; i++)
      if (s < 0 && valid_q[i] && tag_q[i] == req.page) s = i;
    res.hit = (s >= 0);
    case (req.mode)
      lpbd_pkg::MODE_READ: begin
        if (s >= 0) begin
          if (hits_q != '1) hits_q++;
          promote_entry(s);
          slot = s;
        end else begin
          res.backing_request = lpbd_pkg::REQ_FETCH;
          slot = claim_entry(req.page, 1'b0, res);
        end
      end
      lpbd_pkg::MODE_STORE: begin
        if (wt_reg) res.backing_request = lpbd_pkg::REQ_WRITE;
        if (s >= 0) begin
          dirty_q[s] = !wt_reg;
          if (!wt_reg && hits_q != '1) hits_q++;
          promote_entry(s);
          slot = s;
        end else begin
          slot = claim_entry(req.page, !wt_reg, res);
        end
      end
      lpbd_pkg::MODE_INSERT: begin
        res.backing_request = lpbd_pkg::REQ_WRITE;
        if (s >= 0) begin
          dirty_q[s] = 1'b0;
          promote_entry(s);
          slot = s;
        end else begin
          slot = claim_entry(req.page, 1'b0, res);
        end
      end
      default: begin
        res.backing_request = lpbd_pkg::REQ_DELETE;
        if (s >= 0) drop_entry(s);
        slot = 0;
      end
    endcase
    res.slot      = slot[3:0];
    res.hit_count = hits_q;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no outstanding request");
        fail_count++;
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        check_field("hit", 32'(want.hit), 32'(out_data_o.hit));
        check_field("slot", 32'(want.slot), 32'(out_data_o.slot));
        check_field("backing_request", 32'(want.backing_request),
                    32'(out_data_o.backing_request));
        check_field("evicted", 32'(want.evicted), 32'(out_data_o.evicted));
        check_field("evicted_page", want.evicted_page, out_data_o.evicted_page);
        check_field("evict_writeback", 32'(want.evict_writeback),
                    32'(out_data_o.evict_writeback));
        check_field("hit_count", want.hit_count, out_data_o.hit_count);
      end
    end
  end

  // hold off for hold_cycles first, then stall at random
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic issue_page_request(lpbd_pkg::lpbd_mode_e mode, logic [31:0] page);
    lpbd_pkg::lpbd_in_t req;
    req.mode = mode;
    req.page = page;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.insert(pending_replies.size(), predict_directory(req));
  endtask

  task automatic issue_random_request();
    int                   pick;
    lpbd_pkg::lpbd_mode_e mode;
    logic [31:0]          page;
    pick = $urandom_range(0, 99);
    if (pick < 40)      mode = lpbd_pkg::MODE_READ;
    else if (pick < 65) mode = lpbd_pkg::MODE_STORE;
    else if (pick < 85) mode = lpbd_pkg::MODE_INSERT;
    else                mode = lpbd_pkg::MODE_DELETE;
    if ($urandom_range(0, 99) < 85) page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                            page = $urandom();
    issue_page_request(mode, page);
  endtask

  task automatic wait_directory_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_register(lpbd_pkg::lpbd_reg_e which, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lpbd_pkg::ADDR_W'(which) << lpbd_pkg::REG_SEL_BIT;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (which == lpbd_pkg::REG_CAPACITY) cap_reg = value[4:0];
    else                                 wt_reg  = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_directed_access();
    issue_page_request(lpbd_pkg::MODE_READ,   32'h0000_0000);
    issue_page_request(lpbd_pkg::MODE_READ,   32'h0000_0000);
    issue_page_request(lpbd_pkg::MODE_READ,   32'hFFFF_FFFF);
    issue_page_request(lpbd_pkg::MODE_STORE,  32'hFFFF_FFFF);
    issue_page_request(lpbd_pkg::MODE_STORE,  32'h0000_1234);
    issue_page_request(lpbd_pkg::MODE_INSERT, 32'hA5A5_A5A5);
    // insert of a page already held: reused in place, no hit counted
    issue_page_request(lpbd_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    issue_page_request(lpbd_pkg::MODE_DELETE, 32'h0000_0000);
    issue_page_request(lpbd_pkg::MODE_DELETE, 32'h0000_0000);
    // freed entry is the lowest free slot
    issue_page_request(lpbd_pkg::MODE_INSERT, 32'h5A5A_5A5A);
    wait_directory_idle();
  endtask

  task automatic test_capacity_limits();
    // shrink below occupancy: one eviction per allocation
    write_register(lpbd_pkg::REG_CAPACITY, 32'd2);
    issue_page_request(lpbd_pkg::MODE_READ,  32'h0000_0077);
    issue_page_request(lpbd_pkg::MODE_READ,  32'h0000_0078);
    issue_page_request(lpbd_pkg::MODE_STORE, 32'h0000_0079);
    issue_page_request(lpbd_pkg::MODE_READ,  32'h0000_0079);
    wait_directory_idle();
    write_register(lpbd_pkg::REG_CAPACITY, 32'd0);
    issue_page_request(lpbd_pkg::MODE_READ,   32'h0000_0080);
    issue_page_request(lpbd_pkg::MODE_INSERT, 32'h0000_0081);
    issue_page_request(lpbd_pkg::MODE_READ,   32'h0000_0082);
    wait_directory_idle();
    write_register(lpbd_pkg::REG_CAPACITY, 32'd31);
    issue_page_request(lpbd_pkg::MODE_READ, 32'h0000_0083);
    wait_directory_idle();
  endtask

  task automatic test_write_through();
    write_register(lpbd_pkg::REG_CAPACITY, 32'd16);
    write_register(lpbd_pkg::REG_WRITE_THROUGH, 32'd1);
    issue_page_request(lpbd_pkg::MODE_STORE,  32'h0000_0083);
    issue_page_request(lpbd_pkg::MODE_STORE,  32'h0000_0090);
    issue_page_request(lpbd_pkg::MODE_READ,   32'h0000_0090);
    issue_page_request(lpbd_pkg::MODE_INSERT, 32'h0000_0091);
    issue_page_request(lpbd_pkg::MODE_DELETE, 32'h0000_0090);
    wait_directory_idle();
    write_register(lpbd_pkg::REG_WRITE_THROUGH, 32'd0);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_directory_idle();
      write_register(lpbd_pkg::REG_CAPACITY, {27'd0, cap_plan[ph]});
      write_register(lpbd_pkg::REG_WRITE_THROUGH, {31'd0, wt_plan[ph]});
      idle_pct  = idle_plan[ph % 4];
      stall_pct = stall_plan[ph % 4];
      repeat (PHASE_ITEMS) begin
        issue_random_request();
        if ($urandom_range(0, 99) < 2) wait_directory_idle();
      end
    end
    wait_directory_idle();
  endtask

  task automatic test_backpressure();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 400;
    repeat (40) issue_random_request();
    wait_directory_idle();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = $urandom();
    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_access();
    test_capacity_limits();
    test_write_through();
    test_random_traffic();
    test_backpressure();
    wait_directory_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: lru_page_buffer_directory.f
+incdir+src
src/lpbd_pkg.sv
src/lpbd_cfg_regs.sv
src/lpbd_lookup.sv
src/lpbd_state.sv
src/lru_page_buffer_directory.sv
src/lpbd_checker.sv
sim/tb_top.sv
